// ===== rtl/qoi_draft_pixel_encoder_assert.svh =====
// Assertion macros shared by the checker of the draft pixel encoder.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef QOI_DRAFT_PIXEL_ENCODER_ASSERT_SVH
`define QOI_DRAFT_PIXEL_ENCODER_ASSERT_SVH

// Implication in the same cycle, ignored while reset is high.
`define QDPE_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: ante implies cons");

// Implication in the next cycle, ignored while reset is high.
`define QDPE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: ante implies cons next cycle");

// Implication in the next cycle, checked in reset too.
`define QDPE_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed: ante implies cons next cycle");

`endif

// ===== rtl/qdpe_pkg.sv =====
// Shared types and constants of the draft pixel encoder.
// Depends on nothing; used by every module of the block.
package qdpe_pkg;

   localparam int MAX_BYTES = 11;

   localparam logic [13:0] RUN_LIMIT     = 14'h2020;
   localparam logic [13:0] RUN_SHORT_MAX = 14'd33;
   localparam logic [5:0]  HASH_MASK     = 6'd63;
   localparam logic [31:0] RESET_COLOUR  = 32'h0000_00FF;

   localparam logic [7:0] TAG_INDEX  = 8'h00;
   localparam logic [7:0] TAG_RUN8   = 8'h40;
   localparam logic [7:0] TAG_RUN16  = 8'h60;
   localparam logic [7:0] TAG_DIFF8  = 8'h80;
   localparam logic [7:0] TAG_DIFF16 = 8'hC0;
   localparam logic [7:0] TAG_DIFF24 = 8'hE0;
   localparam logic [7:0] TAG_COLOR  = 8'hF0;

   typedef logic [MAX_BYTES-1:0][7:0] byte_vec_type;

   // Bytes caused by one pixel, byte 0 sent first.
   typedef struct packed {
      byte_vec_type bytes;
      logic [3:0]   count;
      logic         end_image;
   } packet_type;

   // Update of the colour index for one pixel.
   typedef struct packed {
      logic        en;
      logic        clear;
      logic [5:0]  hash;
      logic [31:0] colour;
   } idx_wr_type;

   function automatic logic [5:0] colour_hash(input logic [31:0] c);
      logic [7:0] mix;
      mix         = c[31:24] ^ c[23:16] ^ c[15:8] ^ c[7:0];
      colour_hash = mix[5:0] & HASH_MASK;
   endfunction

endpackage

// ===== rtl/qdpe_index.sv =====
// 64-entry colour index: memory with registered read, per-entry valid bits,
// and write forwarding. Depends on qdpe_pkg.
module qdpe_index (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  rd_en,
   input  logic [5:0]            rd_hash,
   input  logic [5:0]            q_hash,
   input  qdpe_pkg::idx_wr_type  wr,
   output logic [31:0]           entry,
   output logic                  entry_valid
);

   logic [31:0] mem [64];
   logic [31:0] rd_data_ff;
   logic        fwd_ff;
   logic [31:0] fwd_data_ff;
   logic [63:0] valid_ff;
   logic [63:0] valid_in;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.hash] <= wr.colour;
      end
      if (rd_en) begin
         rd_data_ff  <= mem[rd_hash];
         fwd_data_ff <= wr.colour;
      end
   end

   // Catch a write landing in the same cycle as the read of the same entry.
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= 1'b0;
      end else if (rd_en) begin
         fwd_ff <= wr.en && (wr.hash == rd_hash);
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (wr.clear) begin
         valid_in = '0;
      end else if (wr.en) begin
         valid_in[wr.hash] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign entry       = fwd_ff ? fwd_data_ff : rd_data_ff;
   assign entry_valid = valid_ff[q_hash];

endmodule

// ===== rtl/qdpe_chunk.sv =====
// Chunk selection for one pixel: run flush, index hit, diff or colour chunk,
// terminator. Pure combinational logic. Depends on qdpe_pkg.
module qdpe_chunk (
   input  logic [31:0]          colour,
   input  logic                 last,
   input  logic [31:0]          prev_colour,
   input  logic [13:0]          run_length,
   input  logic [31:0]          entry,
   input  logic                 entry_valid,
   output qdpe_pkg::packet_type pkt,
   output logic [13:0]          run_next,
   output logic                 idx_write,
   output logic [5:0]           hash
);

   logic              same;
   logic              hit;
   logic [13:0]       run_inc;
   logic              flush;
   logic [13:0]       run_m1;
   logic [13:0]       run_v;
   logic [7:0]        rb [2];
   logic [1:0]        nr;
   logic [7:0]        cb [5];
   logic [2:0]        nc;
   logic [3:0]        nt;
   logic signed [8:0] dr, dg, db, da;
   logic [4:0]        ur, ug, ub, ua;
   logic              f16, f8, f2;
   logic [3:0]        nz;
   logic [3:0]        off;

   assign same    = (colour == prev_colour);
   assign hash    = qdpe_pkg::colour_hash(colour);
   assign hit     = entry_valid ? (entry == colour) : (colour == 32'd0);
   assign run_inc = same ? run_length + 14'd1 : run_length;
   assign flush   = (run_inc != 14'd0) &&
                    ((run_inc == qdpe_pkg::RUN_LIMIT) || !same || last);
   assign run_m1  = run_inc - 14'd1;
   assign run_v   = run_inc - qdpe_pkg::RUN_SHORT_MAX;
   assign idx_write = !same && !hit;

   assign dr = $signed({1'b0, colour[31:24]}) - $signed({1'b0, prev_colour[31:24]});
   assign dg = $signed({1'b0, colour[23:16]}) - $signed({1'b0, prev_colour[23:16]});
   assign db = $signed({1'b0, colour[15:8]})  - $signed({1'b0, prev_colour[15:8]});
   assign da = $signed({1'b0, colour[7:0]})   - $signed({1'b0, prev_colour[7:0]});
   assign ur = dr[4:0];
   assign ug = dg[4:0];
   assign ub = db[4:0];
   assign ua = da[4:0];
   assign nz = {dr != 9'sd0, dg != 9'sd0, db != 9'sd0, da != 9'sd0};

   assign f16 = (dr >= -9'sd16) && (dr <= 9'sd15) && (dg >= -9'sd16) && (dg <= 9'sd15) &&
                (db >= -9'sd16) && (db <= 9'sd15) && (da >= -9'sd16) && (da <= 9'sd15);
   assign f2  = (da == 9'sd0) && (dr >= -9'sd2) && (dr <= 9'sd1) &&
                (dg >= -9'sd2) && (dg <= 9'sd1) && (db >= -9'sd2) && (db <= 9'sd1);
   assign f8  = (da == 9'sd0) && (dg >= -9'sd8) && (dg <= 9'sd7) &&
                (db >= -9'sd8) && (db <= 9'sd7);

   // Run flush bytes.
   always_comb begin
      rb[0] = 8'd0;
      rb[1] = 8'd0;
      nr    = 2'd0;
      if (flush) begin
         if (run_inc < qdpe_pkg::RUN_SHORT_MAX) begin
            rb[0] = qdpe_pkg::TAG_RUN8 | {3'b000, run_m1[4:0]};
            nr    = 2'd1;
         end else begin
            rb[0] = qdpe_pkg::TAG_RUN16 | {3'b000, run_v[12:8]};
            rb[1] = run_v[7:0];
            nr    = 2'd2;
         end
      end
   end

   // Colour chunk bytes.
   always_comb begin
      for (int i = 0; i < 5; i++) begin
         cb[i] = 8'd0;
      end
      nc = 3'd0;
      if (!same) begin
         if (hit) begin
            cb[0] = qdpe_pkg::TAG_INDEX | {2'b00, hash};
            nc    = 3'd1;
         end else if (f16 && f2) begin
            cb[0] = qdpe_pkg::TAG_DIFF8 | {2'b00, ur[1:0], ug[1:0], ub[1:0]};
            nc    = 3'd1;
         end else if (f16 && f8) begin
            cb[0] = qdpe_pkg::TAG_DIFF16 | {3'b000, ur};
            cb[1] = {ug[3:0], ub[3:0]};
            nc    = 3'd2;
         end else if (f16) begin
            cb[0] = qdpe_pkg::TAG_DIFF24 | {4'b0000, ur[4:1]};
            cb[1] = {ur[0], ug, ub[4:3]};
            cb[2] = {ub[2:0], ua};
            nc    = 3'd3;
         end else begin
            cb[0] = qdpe_pkg::TAG_COLOR | {4'b0000, nz};
            nc    = 3'd1;
            // Append changed components in order red, green, blue, alpha.
            for (int i = 0; i < 4; i++) begin
               if (nz[3-i]) begin
                  cb[nc] = colour[31-8*i -: 8];
                  nc     = nc + 3'd1;
               end
            end
         end
      end
   end

   // Lay out run bytes, colour bytes, then the terminator.
   always_comb begin
      nt = last ? 4'd4 : 4'd0;
      pkt.bytes = '0;
      for (int k = 0; k < qdpe_pkg::MAX_BYTES; k++) begin
         off = 4'(k) - {2'b00, nr};
         if (4'(k) < {2'b00, nr}) begin
            pkt.bytes[k] = rb[k % 2];
         end else if (off < {1'b0, nc}) begin
            pkt.bytes[k] = cb[off[2:0]];
         end else begin
            pkt.bytes[k] = 8'd0;
         end
      end
      pkt.count     = {2'b00, nr} + {1'b0, nc} + nt;
      pkt.end_image = last;
   end

   assign run_next = (last || flush) ? 14'd0 : run_inc;

endmodule

// ===== rtl/qdpe_drain.sv =====
// Result register and byte serializer: holds one pixel's chunk bytes and
// sends them one word at a time. Depends on qdpe_pkg.
module qdpe_drain (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  qdpe_pkg::packet_type pkt,
   output logic                 free,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [7:0]           rsp_tdata,
   output logic                 rsp_tuser,
   output logic                 rsp_tlast
);

   qdpe_pkg::byte_vec_type bytes_ff;
   logic [3:0]             cnt_ff;
   logic                   eoi_ff;
   logic                   take;

   assign take       = rsp_tvalid && rsp_tready;
   assign free       = (cnt_ff == 4'd0) || ((cnt_ff == 4'd1) && rsp_tready);
   assign rsp_tvalid = (cnt_ff != 4'd0);
   assign rsp_tdata  = bytes_ff[0];
   assign rsp_tuser  = (cnt_ff == 4'd1);
   assign rsp_tlast  = eoi_ff && (cnt_ff == 4'd1);

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 4'd0;
      end else if (load) begin
         cnt_ff <= pkt.count;
      end else if (take) begin
         cnt_ff <= cnt_ff - 4'd1;
      end
   end

   // Shift the next byte down to the port on each take.
   always_ff @(posedge clock) begin
      if (load) begin
         bytes_ff <= pkt.bytes;
         eoi_ff   <= pkt.end_image;
      end else if (take) begin
         bytes_ff <= {8'd0, bytes_ff[qdpe_pkg::MAX_BYTES-1:1]};
      end
   end

endmodule

// ===== rtl/qoi_draft_pixel_encoder.sv =====
// Draft-format QOI pixel encoder. Takes one RGBA pixel per word on req_ and
// sends the chunk stream one byte per word on rsp_. A pixel waits in the
// input register, where its chunk (run flush, INDEX, DIFF_8/16/24 or
// COLOR, plus four zero terminator bytes on the last pixel) is chosen and
// loaded into the result register; the result register then drains one byte
// per cycle while rsp_tready is high. A pixel that only extends a run passes
// through with no output; the next pixel's chunk is loaded into the result
// register as the last byte of the one before is taken, so the one-byte-wide
// output port goes on without a break when that pixel is waiting. The
// 64-entry colour index is a memory read when a pixel is accepted; its
// per-entry valid bits all clear together at reset and after each last
// pixel, so no clearing pass is needed.
// Depends on qdpe_pkg, qdpe_index, qdpe_chunk and qdpe_drain.
module qoi_draft_pixel_encoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // red[7:0], green[15:8], blue[23:16], alpha[31:24]
   input  logic        req_tlast,   // last_pixel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // out_byte[7:0]
   output logic        rsp_tuser,   // last_of_item[0]
   output logic        rsp_tlast    // end_of_image
);

   logic                 accept;
   logic                 advance;
   logic                 in_valid_ff;
   logic [31:0]          in_colour_ff;
   logic                 in_last_ff;
   logic [31:0]          req_colour;
   logic [31:0]          prev_ff;
   logic [13:0]          run_ff;
   logic [13:0]          run_in;
   logic [31:0]          entry;
   logic                 entry_valid;
   logic                 idx_write;
   logic [5:0]           hash;
   logic                 drain_free;
   qdpe_pkg::packet_type pkt;
   qdpe_pkg::idx_wr_type idx_wr;

   // Internal colour word is R:G:B:A from the msb, as the index stores it.
   assign req_colour = {req_tdata[7:0], req_tdata[15:8], req_tdata[23:16], req_tdata[31:24]};

   // Retire the held pixel when it yields nothing or the result register
   // frees up this cycle; take a new pixel into the freed input register.
   assign advance    = in_valid_ff && ((pkt.count == 4'd0) || drain_free);
   assign req_tready = !in_valid_ff || advance;
   assign accept     = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (accept) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_colour_ff <= req_colour;
         in_last_ff   <= req_tlast;
      end
   end

   // Previous colour and run count advance with each retired pixel and
   // return to their reset values after the last pixel of an image.
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= qdpe_pkg::RESET_COLOUR;
         run_ff  <= 14'd0;
      end else if (advance) begin
         prev_ff <= in_last_ff ? qdpe_pkg::RESET_COLOUR : in_colour_ff;
         run_ff  <= run_in;
      end
   end

   assign idx_wr.en     = advance && idx_write;
   assign idx_wr.clear  = advance && in_last_ff;
   assign idx_wr.hash   = hash;
   assign idx_wr.colour = in_colour_ff;

   qdpe_index u_index (
      .clock       (clock),
      .reset       (reset),
      .rd_en       (accept),
      .rd_hash     (qdpe_pkg::colour_hash(req_colour)),
      .q_hash      (hash),
      .wr          (idx_wr),
      .entry       (entry),
      .entry_valid (entry_valid)
   );

   qdpe_chunk u_chunk (
      .colour      (in_colour_ff),
      .last        (in_last_ff),
      .prev_colour (prev_ff),
      .run_length  (run_ff),
      .entry       (entry),
      .entry_valid (entry_valid),
      .pkt         (pkt),
      .run_next    (run_in),
      .idx_write   (idx_write),
      .hash        (hash)
   );

   qdpe_drain u_drain (
      .clock      (clock),
      .reset      (reset),
      .load       (advance && (pkt.count != 4'd0)),
      .pkt        (pkt),
      .free       (drain_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== rtl/qdpe_checker.sv =====
// Port-level checker of the draft pixel encoder and its bind.
// Depends on qoi_draft_pixel_encoder_assert.svh and the top level.
`include "qoi_draft_pixel_encoder_assert.svh"

module qdpe_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata,
   input logic        rsp_tuser,
   input logic        rsp_tlast
);

   // Hold a stalled output word.
   `QDPE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))

   // End of image closes the last pixel's bytes as well.
   `QDPE_ASSERT_NOW(a_eoi_closes_item, clock, reset, rsp_tvalid && rsp_tlast, rsp_tuser)

   // The closing word of an image is a zero terminator byte.
   `QDPE_ASSERT_NOW(a_eoi_zero, clock, reset, rsp_tvalid && rsp_tlast, rsp_tdata == 8'd0)

   // Drop all pending output on reset.
   `QDPE_ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_tvalid)

endmodule

bind qoi_draft_pixel_encoder qdpe_checker u_qdpe_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
